// ----- sv/btss_pkg.sv -----
// Shared constants, register indexes and the dial frequency table of the beacon slot scheduler.
`default_nettype none

package btss_pkg;

    localparam int unsigned MODE_W    = 2;
    localparam int unsigned BAND_W    = 4;
    localparam int unsigned ADJ_W     = 32;
    localparam int unsigned BCD_W     = 7;
    localparam int unsigned ENT_W     = 8;
    localparam int unsigned FREQ_W    = 32;
    localparam int unsigned PHASE_W   = 2;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned ACC_W     = 5;
    localparam int unsigned OFFSET_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned PROD_W    = FREQ_W + ADJ_W;
    localparam int unsigned UNITY_SHIFT = 19;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx REG_TX_MODE      = 2'd0;
    localparam t_cfg_idx REG_BAND_INDEX   = 2'd1;
    localparam t_cfg_idx REG_CLOCK_ADJUST = 2'd2;

    // Transmit modes.
    localparam t_mode MODE_OFF   = 2'd0;
    localparam t_mode MODE_SCHED = 2'd1;
    localparam t_mode MODE_TEST  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [BAND_W-1:0] BAND_RESET   = 4'd4;
    localparam logic [ADJ_W-1:0]  ADJUST_RESET = 32'h0008_0000;

    // Slot codes, compared against the raw BCD second.
    localparam logic [BCD_W-1:0] SEC_START = 7'h01;
    localparam logic [BCD_W-1:0] SEC_STOP  = 7'h57;

    localparam logic [FREQ_W-1:0] AUDIO_OFFSET_HZ = 32'd1500;
    localparam logic [ACC_W-1:0]  RND_MODULUS     = 5'd31;
    localparam logic signed [OFFSET_W-1:0] RND_CENTRE = 8'sd15;

    // Dial frequencies; indexes beyond the last band saturate to it.
    function automatic logic [FREQ_W-1:0] dial_hz(input logic [BAND_W-1:0] band);
        logic [FREQ_W-1:0] hz;
        case (band)
            4'd0:    hz = 32'd1836600;
            4'd1:    hz = 32'd3568600;
            4'd2:    hz = 32'd7038600;
            4'd3:    hz = 32'd10138700;
            4'd4:    hz = 32'd14095600;
            4'd5:    hz = 32'd18104600;
            4'd6:    hz = 32'd21094600;
            4'd7:    hz = 32'd24924600;
            default: hz = 32'd28124600;
        endcase
        return hz;
    endfunction

endpackage

`default_nettype wire

// ----- sv/beacon_tx_slot_scheduler_core.sv -----
// Beacon transmit slot scheduler: slot state machine, channel draw and frequency computation.
`default_nettype none

// Each accepted item is one real-time clock tick (BCD minute, BCD second and
// an entropy byte) and yields exactly one result item. The block moves between
// off, waiting for a slot and transmitting. In scheduled mode transmission
// starts at second 01 of an even minute and ends at second 57 of an odd minute;
// each end counts a message and draws a new random channel offset of -90 to
// +90 Hz in steps of 6 Hz. In continuous test mode the carrier starts at once
// and never stops, and carrier_only is raised. Any change of tx_mode between
// ticks returns the machine to off first. While off or waiting, the transmit
// frequency is recomputed as (dial + 1500 + offset) * clock_adjust >> 19, so a
// channel drawn at a stop appears on the next tick. While the result channel
// does not stall, the block takes one item per clock cycle: an item is caught
// in an input register, processed by one 32 by 32 bit multiply and the state
// update, and its result is held in a result register, from which it is
// offered. The multiply path sets the clock limit. A stalled result holds the
// input register, and a new item is still taken whenever the input register
// is empty or moving on.
// Configuration is written through a plain write port and should only be
// changed while no item is in flight; writes to unused indexes are ignored.
module beacon_tx_slot_scheduler_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire logic [btss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [btss_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // Input channel.
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [btss_pkg::BCD_W-1:0]         i_minute_bcd,
    input  wire logic [btss_pkg::BCD_W-1:0]         i_second_bcd,
    input  wire logic [btss_pkg::ENT_W-1:0]         i_entropy_byte,
    // Result channel.
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [btss_pkg::FREQ_W-1:0]             o_tx_freq_hz,
    output logic [btss_pkg::PHASE_W-1:0]            o_phase,
    output logic                                    o_start_pulse,
    output logic                                    o_stop_pulse,
    output logic [btss_pkg::COUNT_W-1:0]            o_sent_count,
    output logic                                    o_carrier_only
);
    import btss_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_OFF  = 2'd0,
        PH_WAIT = 2'd1,
        PH_TX   = 2'd2
    } t_phase;

    // Configuration registers.
    t_mode              r_tx_mode;
    logic [BAND_W-1:0]  r_band_index;
    logic [ADJ_W-1:0]   r_clock_adjust;

    // Input register.
    logic               r_in_valid;
    logic [BCD_W-1:0]   r_minute;
    logic [BCD_W-1:0]   r_second;
    logic [ENT_W-1:0]   r_entropy;

    // Scheduler state; the phase, frequency and counter double as result fields.
    t_phase                     r_phase,   n_phase;
    t_mode                      r_prev_mode;
    logic [ACC_W-1:0]           r_rnd_acc, n_rnd_acc;
    logic signed [OFFSET_W-1:0] r_offset,  n_offset;
    logic [COUNT_W-1:0]         r_count,   n_count;
    logic [FREQ_W-1:0]          r_freq,    n_freq;

    // Result register.
    logic r_out_valid;
    logic r_start, n_start;
    logic r_stop,  n_stop;
    logic r_carrier;

    logic advance;
    logic take_in;

    // The processing stage moves on when the result register is free or being emptied.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_mode      <= MODE_OFF;
            r_band_index   <= BAND_RESET;
            r_clock_adjust <= ADJUST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TX_MODE:      r_tx_mode      <= i_cfg_data[MODE_W-1:0];
                REG_BAND_INDEX:   r_band_index   <= i_cfg_data[BAND_W-1:0];
                REG_CLOCK_ADJUST: r_clock_adjust <= i_cfg_data[ADJ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_minute  <= i_minute_bcd;
            r_second  <= i_second_bcd;
            r_entropy <= i_entropy_byte;
        end
    end

    // Per-tick work: mode check, phase step, channel draw and frequency.
    logic                       even_min;
    logic [FREQ_W-1:0]          base_hz;
    logic [PROD_W-1:0]          product;
    logic [ACC_W+3:0]           acc_sum;
    logic [ACC_W:0]             acc_fold;
    logic signed [OFFSET_W-1:0] centred;

    always_comb begin
        even_min  = !r_minute[0];
        n_phase   = r_phase;
        n_rnd_acc = r_rnd_acc;
        n_offset  = r_offset;
        n_count   = r_count;
        n_freq    = r_freq;
        n_start   = 1'b0;
        n_stop    = 1'b0;

        // A mode change since the previous tick, or mode off, forces the machine off.
        if (r_prev_mode != r_tx_mode) begin
            n_phase = PH_OFF;
        end
        if (r_tx_mode == MODE_OFF) begin
            n_phase = PH_OFF;
        end else if (n_phase == PH_OFF) begin
            n_phase = PH_WAIT;
        end
        // Only scheduled mode keeps its drawn channel.
        if (r_tx_mode != MODE_SCHED) begin
            n_offset = '0;
        end

        base_hz = dial_hz(r_band_index) + AUDIO_OFFSET_HZ
                + {{(FREQ_W-OFFSET_W){n_offset[OFFSET_W-1]}}, n_offset};
        product = PROD_W'(base_hz) * PROD_W'(r_clock_adjust);

        // Since 32 is one more than 31, folding the high bits onto the low
        // bits and one conditional subtract gives the remainder.
        acc_sum  = (ACC_W+4)'(r_rnd_acc) + (ACC_W+4)'(r_entropy);
        acc_fold = (ACC_W+1)'(acc_sum[ACC_W+3:ACC_W]) + (ACC_W+1)'(acc_sum[ACC_W-1:0]);
        if (acc_fold >= (ACC_W+1)'(RND_MODULUS)) begin
            acc_fold = acc_fold - (ACC_W+1)'(RND_MODULUS);
        end
        centred = $signed({{(OFFSET_W-ACC_W-1){1'b0}}, acc_fold}) - RND_CENTRE;

        case (n_phase)
            PH_OFF: begin
                n_freq = product[UNITY_SHIFT +: FREQ_W];
            end
            PH_WAIT: begin
                n_freq = product[UNITY_SHIFT +: FREQ_W];
                if ((even_min && r_second == SEC_START) || r_tx_mode == MODE_TEST) begin
                    n_phase = PH_TX;
                    n_start = 1'b1;
                end
            end
            PH_TX: begin
                if (!even_min && r_second == SEC_STOP && r_tx_mode != MODE_TEST) begin
                    n_phase   = PH_WAIT;
                    n_count   = r_count + COUNT_W'(1);
                    n_stop    = 1'b1;
                    n_rnd_acc = acc_fold[ACC_W-1:0];
                    n_offset  = (centred <<< 2) + (centred <<< 1);
                end
            end
            default: ;
        endcase
    end

    // State and result registers, loaded together when an item is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OFF;
            r_prev_mode <= MODE_OFF;
            r_rnd_acc   <= '0;
            r_offset    <= '0;
            r_count     <= '0;
            r_freq      <= '0;
            r_out_valid <= 1'b0;
            r_start     <= 1'b0;
            r_stop      <= 1'b0;
            r_carrier   <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_phase     <= n_phase;
                r_prev_mode <= r_tx_mode;
                r_rnd_acc   <= n_rnd_acc;
                r_offset    <= n_offset;
                r_count     <= n_count;
                r_freq      <= n_freq;
                r_start     <= n_start;
                r_stop      <= n_stop;
                r_carrier   <= (r_tx_mode == MODE_TEST);
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_tx_freq_hz   = r_freq;
    assign o_phase        = r_phase;
    assign o_start_pulse  = r_start;
    assign o_stop_pulse   = r_stop;
    assign o_sent_count   = r_count;
    assign o_carrier_only = r_carrier;

endmodule

`default_nettype wire
